// ----- rtl/waveform_sample_generator_top_macros.svh -----
// Assertion helpers for the checker file.
`ifndef WAVEFORM_SAMPLE_GENERATOR_TOP_MACROS_SVH
`define WAVEFORM_SAMPLE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WSG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define WSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/wsg_pkg.sv -----
package wsg_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int N_STEPS      = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

   // x, y in Q2.30 with headroom; angle in 2^-32 turn with headroom
   localparam int CW = 34;
   localparam int ZW = 34;

   localparam int FREQ_W   = 24;
   localparam int TIME_W   = 32;
   localparam int OFFS_W   = 16;
   localparam int SAMPLE_W = 16;
   localparam int PHASE_W  = 32;
   localparam int PROD_W   = FREQ_W + TIME_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [CW-1:0] CORDIC_X0 = 34'sh0_26DD_3B6A;

   localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   typedef enum logic [1:0] {
      KIND_SINE     = 2'd0,
      KIND_SQUARE   = 2'd1,
      KIND_TRIANGLE = 2'd2,
      KIND_SAWTOOTH = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_IDX_KIND = 1'b0,
      CSR_IDX_NONE = 1'b1
   } csr_idx_type;

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [33:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > 34'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -34'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/waveform_sample_generator_top.sv -----
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall freq, sample_time, phase_offset
// rsp       out        rsp_valid/rsp_stall sample (signed Q1.15)
// csr       in         APB, pready tied    waveform_kind at byte address 0
//
// One item per cycle while the result is not stalled; the stages are multiply,
// fold, one CORDIC micro-rotation per stage, and the output register.
// Reset clears the valid bits and selects the sine waveform.
// A stalled result holds the whole pipeline; req_stall rises only then.
module waveform_sample_generator_top
   import wsg_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [FREQ_W-1:0]            req_freq,
   input  logic [TIME_W-1:0]            req_sample_time,
   input  logic [OFFS_W-1:0]            req_phase_offset,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SAMPLE_W-1:0]   rsp_sample,

   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_W-1:0]        paddr,
   input  logic [CSR_DATA_W-1:0]        pwdata,
   output logic [CSR_DATA_W-1:0]        prdata,
   output logic                         pready
);

   // ---------------- configuration ----------------
   kind_type    kind_ff, kind_in;
   csr_idx_type csr_idx;
   logic        csr_wr;

   assign csr_idx = csr_idx_type'(paddr[2]);
   assign csr_wr  = psel && penable && pwrite && pready;
   assign pready  = 1'b1;

   always_comb begin
      kind_in = kind_ff;
      if (csr_wr && csr_idx == CSR_IDX_KIND) begin
         kind_in = kind_type'(pwdata[1:0]);
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_IDX_KIND: prdata = {{(CSR_DATA_W-2){1'b0}}, kind_ff};
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_SINE;
      end else begin
         kind_ff <= kind_in;
      end
   end

   // ---------------- pipeline advance ----------------
   logic rsp_valid_ff;
   logic adv;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ---------------- stage A: multiply ----------------
   logic              a_vld_ff;
   logic [32:0]       a_prod_ff;
   logic [OFFS_W-1:0] a_offs_ff;
   logic [PROD_W-1:0] prod_full;

   assign prod_full = PROD_W'(req_freq) * PROD_W'(req_sample_time);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_prod_ff <= prod_full[32:0];
         a_offs_ff <= req_phase_offset;
      end
   end

   // ---------------- stage B: phase, fold, piecewise waveforms ----------------
   logic signed [CW-1:0]       x_ff [0:N_STEPS];
   logic signed [CW-1:0]       y_ff [0:N_STEPS];
   logic signed [ZW-1:0]       z_ff [0:N_STEPS];
   logic signed [SAMPLE_W-1:0] alt_ff [0:N_STEPS];
   logic                       sine_ff [0:N_STEPS];
   logic                       vld_ff [0:N_STEPS];

   logic [32:0]                comb_w;
   logic [PHASE_W-1:0]         p_w;
   logic [15:0]                h_hi_w;
   logic [16:0]                p_hi_w;
   logic signed [ZW-1:0]       s_w;
   logic signed [ZW-1:0]       z0_w;
   logic signed [33:0]         alt_w;

   assign comb_w = a_prod_ff + {1'b0, a_offs_ff, 16'b0};
   assign p_w    = comb_w[PHASE_W-1:0];
   assign h_hi_w = comb_w[32:17];
   assign p_hi_w = p_w[31:15];
   assign s_w    = {{(ZW-PHASE_W){p_w[31]}}, p_w};

   // fold into [-1/4, +1/4] turn using sin(1/2 - x) = sin(x)
   always_comb begin
      if (s_w > 34'sh0_4000_0000) begin
         z0_w = 34'sh0_8000_0000 - s_w;
      end else if (s_w < -34'sh0_4000_0000) begin
         z0_w = -34'sh0_8000_0000 - s_w;
      end else begin
         z0_w = s_w;
      end
   end

   always_comb begin
      unique case (kind_ff)
         KIND_SQUARE:   alt_w = (p_w > 32'h8000_0000) ? 34'sd32767 : -34'sd32768;
         KIND_TRIANGLE: alt_w = p_w[31] ? (34'(p_hi_w) - 34'sd98304)
                                        : (34'sd32768 - 34'(p_hi_w));
         KIND_SAWTOOTH: alt_w = 34'sd32768 - 34'(h_hi_w);
         default:       alt_w = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= CORDIC_X0;
         y_ff[0]    <= '0;
         z_ff[0]    <= z0_w;
         alt_ff[0]  <= sat16(alt_w);
         sine_ff[0] <= (kind_ff == KIND_SINE);
      end
   end

   // ---------------- CORDIC: one micro-rotation per stage ----------------
   for (genvar i = 0; i < N_STEPS; i++) begin : g_cordic
      localparam logic signed [ZW-1:0] ATAN_I = ZW'(ATAN_TURNS[i]);
      logic signed [CW-1:0] dx_w, dy_w;

      assign dx_w = y_ff[i] >>> i;
      assign dy_w = x_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (!z_ff[i][ZW-1]) begin
               x_ff[i+1] <= x_ff[i] - dx_w;
               y_ff[i+1] <= y_ff[i] + dy_w;
               z_ff[i+1] <= z_ff[i] - ATAN_I;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx_w;
               y_ff[i+1] <= y_ff[i] - dy_w;
               z_ff[i+1] <= z_ff[i] + ATAN_I;
            end
            alt_ff[i+1]  <= alt_ff[i];
            sine_ff[i+1] <= sine_ff[i];
         end
      end
   end

   // ---------------- output register ----------------
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic signed [CW-1:0]       y_round_w;

   // round to nearest, ties upward
   assign y_round_w     = (y_ff[N_STEPS] + 34'sh0_0000_4000) >>> 15;
   assign rsp_sample_in = sine_ff[N_STEPS] ? sat16(y_round_w) : alt_ff[N_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[N_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

// ----- rtl/wsg_checker.sv -----
`include "waveform_sample_generator_top_macros.svh"

module wsg_checker
   import wsg_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [SAMPLE_W-1:0] rsp_sample
);

   logic rsp_held;

   assign rsp_held = rsp_valid && rsp_stall;

   // hold a stalled transfer on the result side
   `WSG_ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_held, rsp_valid, "rsp_valid dropped")
   `WSG_ASSERT_NEXT(a_rsp_data_hold, clock, reset, rsp_held, $stable(rsp_sample), "data moved")
   // input backpressure only comes from a blocked result
   `WSG_ASSERT_NOW(a_req_stall_cause, clock, reset, req_stall, rsp_held, "stray req_stall")

endmodule

bind waveform_sample_generator_top wsg_checker u_wsg_checker (.*);

// ----- dv/tb_waveform_sample_generator_top.sv -----
module tb_waveform_sample_generator_top;
   import wsg_pkg::*;

   localparam int ROT_STEPS   = 16;
   localparam int ROT_ACTIVE  = (ROT_STEPS > 24) ? 24 : ROT_STEPS;
   localparam int DRAIN_WAIT  = 40;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct packed {
      kind_type    kind;
      logic [23:0] freq;
      logic [31:0] stamp;
      logic [15:0] offset;
      logic        fixed;
      logic [15:0] sample;
   } probe_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [FREQ_W-1:0]          req_freq = '0;
   logic [TIME_W-1:0]          req_sample_time = '0;
   logic [OFFS_W-1:0]          req_phase_offset = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]      paddr = '0;
   logic [CSR_DATA_W-1:0]      pwdata = '0;
   logic [CSR_DATA_W-1:0]      prdata;
   logic                       pready;

   kind_type    model_kind = KIND_SINE;
   logic [15:0] pending_samples [$];
   logic        row_fixed = 1'b0;
   logic [15:0] row_sample = '0;
   logic [15:0] want;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   waveform_sample_generator_top dut (.*);

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   function automatic longint rot_angle(int i);
      case (i)
         0:  return 64'h20000000;
         1:  return 64'h12E4051E;
         2:  return 64'h09FB385B;
         3:  return 64'h051111D4;
         4:  return 64'h028B0D43;
         5:  return 64'h0145D7E1;
         6:  return 64'h00A2F61E;
         7:  return 64'h00517C55;
         8:  return 64'h0028BE53;
         9:  return 64'h00145F2F;
         10: return 64'h000A2F98;
         11: return 64'h000517CC;
         12: return 64'h00028BE6;
         13: return 64'h000145F3;
         14: return 64'h0000A2F9;
         15: return 64'h0000517C;
         16: return 64'h000028BE;
         17: return 64'h0000145F;
         18: return 64'h00000A2F;
         19: return 64'h00000517;
         20: return 64'h0000028B;
         21: return 64'h00000145;
         22: return 64'h000000A2;
         default: return 64'h00000051;
      endcase
   endfunction

   function automatic logic [15:0] clip_q15(longint v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   function automatic logic [15:0] sine_q15(logic [31:0] p);
      longint x, y, z, dx, dy;
      z = longint'($signed(p));
      // fold into [-1/4, +1/4] turn, sin(1/2 - a) = sin(a)
      if (z > 64'sh4000_0000) begin
         z = 64'sh8000_0000 - z;
      end else if (z < -64'sh4000_0000) begin
         z = -64'sh8000_0000 - z;
      end
      x = 64'sh26DD_3B6A;
      y = 0;
      for (int i = 0; i < ROT_ACTIVE; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - rot_angle(i);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + rot_angle(i);
         end
      end
      return clip_q15((y + 64'sh4000) >>> 15);
   endfunction

   function automatic logic [15:0] osc_sample(kind_type kind, logic [23:0] f, logic [31:0] t,
                                              logic [15:0] off);
      logic [63:0] combined;
      logic [31:0] p;
      logic [31:0] h;
      longint      v;
      combined = 64'(f) * 64'(t) + (64'(off) << 16);
      p = combined[31:0];
      h = combined[32:1];
      case (kind)
         KIND_SINE: return sine_q15(p);
         KIND_SQUARE: v = (p > 32'h8000_0000) ? 32767 : -32768;
         KIND_TRIANGLE: begin
            if (p < 32'h8000_0000) begin
               v = 32768 - longint'(p >> 15);
            end else begin
               v = longint'(p >> 15) - 98304;
            end
         end
         default: v = 32768 - longint'(h >> 16);
      endcase
      return clip_q15(v);
   endfunction

   function automatic logic [31:0] pick_field(int unsigned width);
      logic [63:0] mask;
      int unsigned r;
      mask = (64'd1 << width) - 64'd1;
      r = $urandom_range(7);
      if (r == 0) return '0;
      if (r == 1) return mask[31:0];
      return $urandom & mask[31:0];
   endfunction

   task automatic note_mismatch(string what, logic [31:0] expected, logic [31:0] actual);
      error_count++;
      if (error_count <= 10) begin
         $display("%s: expected 0x%h, got 0x%h", what, expected, actual);
      end
   endtask

   // Predict on every accepted transfer, check every returned one.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_samples.push_back(row_fixed ? row_sample :
               osc_sample(model_kind, req_freq, req_sample_time, req_phase_offset));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_samples.size() == 0) begin
               note_mismatch("sample with nothing pending", '0, 32'(rsp_sample));
            end else begin
               want = pending_samples.pop_front();
               if (rsp_sample !== want) begin
                  note_mismatch("sample", 32'(want), 32'(rsp_sample));
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Enter and leave at a falling edge with no request-side assignment pending.
   task automatic push_request(logic [23:0] f, logic [31:0] t, logic [15:0] off,
                               logic fixed, logic [15:0] sample);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_freq <= f;
      req_sample_time <= t;
      req_phase_offset <= off;
      row_fixed = fixed;
      row_sample = sample;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic csr_xfer(logic wr, csr_idx_type idx, logic [31:0] wdata,
                           output logic [31:0] rdata);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      if (wr && idx == CSR_IDX_KIND) begin
         model_kind = kind_type'(wdata[1:0]);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
   endtask

   task automatic check_kind_readback();
      logic [31:0] rd;
      csr_xfer(1'b0, CSR_IDX_KIND, '0, rd);
      if (rd !== {30'd0, model_kind}) begin
         note_mismatch("waveform_kind readback", {30'd0, model_kind}, rd);
      end
   endtask

   task automatic select_kind(kind_type kind);
      logic [31:0] rd;
      drain_pipeline();
      // upper bits are junk and must be dropped
      csr_xfer(1'b1, CSR_IDX_KIND, ($urandom & 32'hFFFF_FFFC) | 32'(kind), rd);
      check_kind_readback();
   endtask

   initial begin : stimulus
      probe_row_type probes [22];
      logic [31:0]   rd;
      logic [1:0]    first_kind;
      probes = '{
         '{KIND_SINE,     24'h0,      32'h0,        16'h0000, 1'b0, 16'h0000},
         '{KIND_SINE,     24'h0,      32'h0,        16'h4000, 1'b0, 16'h0000},
         '{KIND_SINE,     24'h0,      32'h0,        16'h6000, 1'b0, 16'h0000},
         '{KIND_SINE,     24'h0,      32'h0,        16'hA000, 1'b0, 16'h0000},
         '{KIND_SINE,     24'h0,      32'h0,        16'hC000, 1'b0, 16'h0000},
         '{KIND_SINE,     24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b0, 16'h0000},
         '{KIND_SQUARE,   24'h0,      32'h0,        16'h0000, 1'b1, 16'h8000},
         '{KIND_SQUARE,   24'h0,      32'h0,        16'h8000, 1'b1, 16'h8000},
         '{KIND_SQUARE,   24'h0,      32'h0,        16'h8001, 1'b1, 16'h7FFF},
         '{KIND_SQUARE,   24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b0, 16'h0000},
         '{KIND_TRIANGLE, 24'h0,      32'h0,        16'h0000, 1'b1, 16'h7FFF},
         '{KIND_TRIANGLE, 24'h0,      32'h0,        16'h4000, 1'b1, 16'h0000},
         '{KIND_TRIANGLE, 24'h0,      32'h0,        16'h8000, 1'b1, 16'h8000},
         '{KIND_TRIANGLE, 24'h0,      32'h0,        16'hC000, 1'b1, 16'h0000},
         '{KIND_TRIANGLE, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b0, 16'h0000},
         '{KIND_SAWTOOTH, 24'h0,      32'h0,        16'h0000, 1'b1, 16'h7FFF},
         '{KIND_SAWTOOTH, 24'h0,      32'h0,        16'h8000, 1'b1, 16'h4000},
         // one full turn: phase wraps to zero but the half phase does not
         '{KIND_SAWTOOTH, 24'h100,    32'h01000000, 16'h0000, 1'b1, 16'h0000},
         '{KIND_SAWTOOTH, 24'h100,    32'h01000000, 16'h8000, 1'b1, 16'hC000},
         '{KIND_SAWTOOTH, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 1'b0, 16'h0000},
         '{KIND_SINE,     24'h1,      32'hFFFFFFFF, 16'h0000, 1'b0, 16'h0000},
         '{KIND_SINE,     24'hFFFFFF, 32'h1,        16'h0000, 1'b0, 16'h0000}
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 9;
      recv_stall_pct = 80;
      check_kind_readback();

      foreach (probes[i]) begin
         if (probes[i].kind != model_kind) begin
            select_kind(probes[i].kind);
         end
         push_request(probes[i].freq, probes[i].stamp, probes[i].offset,
                      probes[i].fixed, probes[i].sample);
      end

      // a write to the unused index must leave the waveform alone
      drain_pipeline();
      csr_xfer(1'b1, CSR_IDX_NONE, $urandom, rd);
      check_kind_readback();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 80 : 0;
         recv_stall_pct = (phase == 0) ? 80 : (phase == 1) ? 9 : 0;
         first_kind = 2'($urandom_range(3));
         for (int k = 0; k < 4; k++) begin
            select_kind(kind_type'(first_kind + 2'(k)));
            repeat (134) begin
               push_request(24'(pick_field(24)), pick_field(32), 16'(pick_field(16)),
                            1'b0, '0);
            end
         end
      end

      drain_pipeline();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/wsg_pkg.sv
rtl/waveform_sample_generator_top.sv
rtl/wsg_checker.sv
dv/tb_waveform_sample_generator_top.sv
